// ===== sv/jet_pkg.sv =====
// Shared types and constants for the Julia escape-time block.
// No dependencies; imported by julia_escape_time.
package jet_pkg;

  localparam int FracBitsDefault     = 28;
  localparam int MaxIterBoundDefault = 1024;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 31;
  localparam int CountW   = 11;

  localparam logic [CfgIdxW-1:0] REG_C_REAL          = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_C_IMAG          = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ITERATION_LIMIT = 2'd2;

  localparam logic [CountW-1:0] LimitReset = 11'd250;

  typedef struct packed {
    logic signed [31:0] start_real;
    logic signed [31:0] start_imag;
  } in_t;

  typedef struct packed {
    logic [CountW-1:0] escape_count;
    logic              escaped;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_XX,
    S_MUL_YY,
    S_MUL_XY,
    S_UPDATE
  } state_t;

endpackage

// ===== sv/julia_escape_time.sv =====
// Julia set escape-time engine: one shared 32x32 multiplier under a small sequencer.
// Depends on jet_pkg (payload structs, register indexes, state enum).
//
// Usage:
//   Input: present z0 on in_data and raise start; the transfer happens at a clock
//   edge with start high and busy low. busy stays high while the point iterates.
//   Output: out_valid pulses for one cycle with out_data (escape_count, escaped).
//   The receiver cannot stall; it must take the result in that cycle.
//   Config: cfg_we/cfg_idx/cfg_wdata write c_real (0), c_imag (1) and
//   iteration_limit (2); other indexes are ignored. Write only while idle.
// Operation:
//   Each iteration runs three products through the one multiplier
//   (x*x, y*y, x*y) and an update step that forms the new z and tests the
//   magnitude of the previous update. A zero limit answers from idle with
//   escape_count 0 and escaped low, without iterating. The block takes no new
//   point until the current result is out, as busy stays high meanwhile.
// Reset:
//   Synchronous active-low rst_n returns the sequencer to idle, drops out_valid
//   and restores c = 0 and iteration_limit = 250.
module julia_escape_time #(
  parameter int FRAC_BITS      = jet_pkg::FracBitsDefault,
  parameter int MAX_ITER_BOUND = jet_pkg::MaxIterBoundDefault
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  jet_pkg::in_t                 in_data,
  output logic                         out_valid,
  output jet_pkg::out_t                out_data,
  input  logic                         cfg_we,
  input  logic [jet_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [jet_pkg::CfgDataW-1:0] cfg_wdata
);
  import jet_pkg::*;

  // Escape threshold 4 in Q(2*FRAC_BITS); unreachable when it needs 64+ bits.
  localparam int          ThrShift = 2 * FRAC_BITS + 2;
  localparam bit          Reach    = (ThrShift < 64);
  localparam logic [63:0] Thresh   = Reach ? (64'd1 << ThrShift) : 64'd0;

  localparam logic signed [63:0] Sat32Max = 64'sd2147483647;
  localparam logic signed [63:0] Sat32Min = -64'sd2147483648;

  // config registers
  logic signed [30:0]  c_real_r, c_imag_r;
  logic [CountW-1:0]   limit_r;

  // sequencer and datapath
  state_t              state_r, state_nxt;
  logic signed [31:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [63:0]  prod_r, prod_nxt;
  logic signed [63:0]  xx_r, xx_nxt, yy_r, yy_nxt;
  logic [CountW-1:0]   k_r, k_nxt;
  logic [CountW-1:0]   lim_r, lim_nxt;
  logic                first_r, first_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r, out_data_nxt;

  logic signed [31:0]  mul_a, mul_b;
  logic signed [63:0]  diff, nx_wide, ny_wide;
  logic signed [31:0]  nx_sat, ny_sat;
  logic [63:0]         mag;
  logic                escape_hit, last_iter, in_xfer;
  logic [CountW-1:0]   limit_eff;

  assign busy      = (state_r != S_IDLE);
  assign in_xfer   = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Limit clamp against the build-time bound.
  assign limit_eff = (32'(limit_r) > 32'(MAX_ITER_BOUND)) ? CountW'(MAX_ITER_BOUND) : limit_r;

  // Shared multiplier; operands chosen by the sequencer, product registered.
  always_comb begin
    unique case (state_r)
      S_MUL_YY: begin
        mul_a = y_r;
        mul_b = y_r;
      end
      S_MUL_XY: begin
        mul_a = x_r;
        mul_b = y_r;
      end
      default: begin
        mul_a = x_r;
        mul_b = x_r;
      end
    endcase
  end
  assign prod_nxt = mul_a * mul_b;

  // Update math: in S_UPDATE, xx_r/yy_r hold x^2/y^2 and prod_r holds x*y.
  assign diff    = xx_r - yy_r;
  assign nx_wide = (diff >>> FRAC_BITS) + 64'(c_real_r);
  assign ny_wide = (prod_r >>> (FRAC_BITS - 1)) + 64'(c_imag_r);
  assign nx_sat  = (nx_wide > Sat32Max) ? 32'(Sat32Max) :
                   (nx_wide < Sat32Min) ? 32'(Sat32Min) : 32'(nx_wide);
  assign ny_sat  = (ny_wide > Sat32Max) ? 32'(Sat32Max) :
                   (ny_wide < Sat32Min) ? 32'(Sat32Min) : 32'(ny_wide);

  // Squares of the current z are the magnitude of the previous update.
  assign mag        = 64'(xx_r) + 64'(yy_r);
  assign escape_hit = Reach && (mag > Thresh);
  assign last_iter  = (({1'b0, k_r} + (CountW+1)'(1)) == {1'b0, lim_r});

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && (limit_eff != '0)) state_nxt = S_MUL_XX;
      end
      S_MUL_XX: state_nxt = S_MUL_YY;
      S_MUL_YY: state_nxt = S_MUL_XY;
      S_MUL_XY: state_nxt = S_UPDATE;
      S_UPDATE: begin
        if (!first_r && (escape_hit || last_iter)) state_nxt = S_IDLE;
        else                                       state_nxt = S_MUL_XX;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and result
  always_comb begin
    x_nxt         = x_r;
    y_nxt         = y_r;
    xx_nxt        = xx_r;
    yy_nxt        = yy_r;
    k_nxt         = k_r;
    lim_nxt       = lim_r;
    first_nxt     = first_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          x_nxt     = in_data.start_real;
          y_nxt     = in_data.start_imag;
          k_nxt     = '0;
          lim_nxt   = limit_eff;
          first_nxt = 1'b1;
          if (limit_eff == '0) begin
            out_valid_nxt             = 1'b1;
            out_data_nxt.escape_count = '0;
            out_data_nxt.escaped      = 1'b0;
          end
        end
      end
      S_MUL_YY: xx_nxt = prod_r;
      S_MUL_XY: yy_nxt = prod_r;
      S_UPDATE: begin
        if (!first_r && escape_hit) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.escape_count = k_r;
          out_data_nxt.escaped      = 1'b1;
        end else if (!first_r && last_iter) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.escape_count = lim_r;
          out_data_nxt.escaped      = 1'b0;
        end else begin
          // apply update for the next iteration index
          x_nxt     = nx_sat;
          y_nxt     = ny_sat;
          first_nxt = 1'b0;
          if (!first_r) k_nxt = k_r + CountW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      c_real_r    <= '0;
      c_imag_r    <= '0;
      limit_r     <= LimitReset;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_C_REAL:          c_real_r <= cfg_wdata;
          REG_C_IMAG:          c_imag_r <= cfg_wdata;
          REG_ITERATION_LIMIT: limit_r  <= cfg_wdata[CountW-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    prod_r     <= prod_nxt;
    xx_r       <= xx_nxt;
    yy_r       <= yy_nxt;
    k_r        <= k_nxt;
    lim_r      <= lim_nxt;
    first_r    <= first_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
